// ----- sv/pcdc_pkg.sv -----
`default_nettype none
package pcdc_pkg;

  localparam int ADDR_W     = 32;
  localparam int PC_W       = 32;
  localparam int DEG_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PHYS_ADDR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE        = 1'd1;

  // Input command codes.
  localparam logic CMD_ACCESS   = 1'b0;
  localparam logic CMD_COMPLETE = 1'b1;

  localparam logic [ADDR_W-1:0] MAX_PHYS_ADDR_RST = 32'hFFFF_FFFF;
  localparam logic [DEG_W-1:0]  DEGREE_RST        = 5'd4;

  localparam int INDEX_ENTRIES_DEF    = 64;
  localparam int HISTORY_ENTRIES_DEF  = 256;
  localparam int MAX_DEGREE_DEF       = 16;
  localparam int INFLIGHT_ENTRIES_DEF = 16;
  localparam int MAX_DELTAS_DEF       = 64;

  localparam int MIN_DELTAS  = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic              cmd;
    logic [PC_W-1:0]   pc;
    logic [ADDR_W-1:0] addr;
  } item_t;

endpackage
`default_nettype wire

// ----- sv/pc_delta_correlation_prefetcher.sv -----
`default_nettype none
// A completion takes effect when the idle back pops it from the queue; the queue holds 2.
// A trained miss runs the index scan and update, then walks its delta chain, searches the deltas
// and generates candidates; the index scan reads one entry per cycle.
// Results leave one per strobe cycle; the receiver cannot stall them.
// Synchronous active-low reset clears index and in-flight valid bits, history head and LRU order.
module pc_delta_correlation_prefetcher #(
  parameter int INDEX_ENTRIES    = pcdc_pkg::INDEX_ENTRIES_DEF,
  parameter int HISTORY_ENTRIES  = pcdc_pkg::HISTORY_ENTRIES_DEF,
  parameter int MAX_DEGREE       = pcdc_pkg::MAX_DEGREE_DEF,
  parameter int INFLIGHT_ENTRIES = pcdc_pkg::INFLIGHT_ENTRIES_DEF,
  parameter int MAX_DELTAS       = pcdc_pkg::MAX_DELTAS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_cmd,
  input  wire logic                              in_is_miss,
  input  wire logic [pcdc_pkg::PC_W-1:0]         in_pc,
  input  wire logic [pcdc_pkg::ADDR_W-1:0]       in_block_addr,
  output logic                                   out_strobe,
  output logic [pcdc_pkg::ADDR_W-1:0]            out_prefetch_addr,
  output logic                                   out_last,
  input  wire logic                              cfg_we,
  input  wire logic [pcdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pcdc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pcdc_pkg::*;

  logic [ADDR_W-1:0] max_phys_r;
  logic [DEG_W-1:0]  degree_r;
  logic              q_push, q_pop, q_empty, q_full;
  item_t             push_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_phys_r <= MAX_PHYS_ADDR_RST;
      degree_r   <= DEGREE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_PHYS_ADDR: max_phys_r <= cfg_wdata[ADDR_W-1:0];
        CFG_DEGREE:        degree_r   <= cfg_wdata[DEG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pcdc_front u_front (
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_is_miss    (in_is_miss),
    .in_pc         (in_pc),
    .in_block_addr (in_block_addr),
    .max_phys_addr (max_phys_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  pcdc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  pcdc_back #(
    .INDEX_ENTRIES    (INDEX_ENTRIES),
    .HISTORY_ENTRIES  (HISTORY_ENTRIES),
    .MAX_DEGREE       (MAX_DEGREE),
    .INFLIGHT_ENTRIES (INFLIGHT_ENTRIES),
    .MAX_DELTAS       (MAX_DELTAS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_item        (pop_item),
    .q_pop         (q_pop),
    .max_phys_addr (max_phys_r),
    .degree        (degree_r),
    .out_valid     (out_strobe),
    .out_addr      (out_prefetch_addr),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

// ----- sv/pcdc_ram.sv -----
`default_nettype none
module pcdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/pcdc_front.sv -----
`default_nettype none
module pcdc_front (
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     in_cmd,
  input  wire logic                     in_is_miss,
  input  wire logic [pcdc_pkg::PC_W-1:0]   in_pc,
  input  wire logic [pcdc_pkg::ADDR_W-1:0] in_block_addr,
  input  wire logic [pcdc_pkg::ADDR_W-1:0] max_phys_addr,
  input  wire logic                     q_full,
  output logic                          q_push,
  output pcdc_pkg::item_t               q_item
);
  import pcdc_pkg::*;

  logic usable_miss;
  logic keep;

  // Only completions and misses that can train reach the back part.
  assign usable_miss = (in_cmd == CMD_ACCESS) && in_is_miss &&
                       (in_block_addr != '0) && (in_block_addr < max_phys_addr);
  assign keep        = (in_cmd == CMD_COMPLETE) || usable_miss;

  assign busy   = q_full;
  assign q_push = start && !q_full && keep;
  assign q_item = '{cmd: in_cmd, pc: in_pc, addr: in_block_addr};

endmodule
`default_nettype wire

// ----- sv/pcdc_fifo.sv -----
`default_nettype none
module pcdc_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire pcdc_pkg::item_t push_item,
  input  wire logic            pop,
  output pcdc_pkg::item_t      pop_item,
  output logic                 empty,
  output logic                 full
);
  import pcdc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign pop_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !empty)
    else $error("queue empty after a push");

endmodule
`default_nettype wire

// ----- sv/pcdc_back.sv -----
`default_nettype none
module pcdc_back #(
  parameter int INDEX_ENTRIES    = pcdc_pkg::INDEX_ENTRIES_DEF,
  parameter int HISTORY_ENTRIES  = pcdc_pkg::HISTORY_ENTRIES_DEF,
  parameter int MAX_DEGREE       = pcdc_pkg::MAX_DEGREE_DEF,
  parameter int INFLIGHT_ENTRIES = pcdc_pkg::INFLIGHT_ENTRIES_DEF,
  parameter int MAX_DELTAS       = pcdc_pkg::MAX_DELTAS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  wire pcdc_pkg::item_t             q_item,
  output logic                             q_pop,
  input  wire logic [pcdc_pkg::ADDR_W-1:0] max_phys_addr,
  input  wire logic [pcdc_pkg::DEG_W-1:0]  degree,
  output logic                             out_valid,
  output logic [pcdc_pkg::ADDR_W-1:0]      out_addr,
  output logic                             out_last
);
  import pcdc_pkg::*;

  localparam int IW    = $clog2(INDEX_ENTRIES);
  localparam int HW    = $clog2(HISTORY_ENTRIES);
  localparam int HW1   = HW + 1;
  localparam int DW    = $clog2(MAX_DELTAS);
  localparam int NW    = $clog2(MAX_DELTAS + 1);
  localparam int LIM_W = $clog2(MAX_DEGREE + 1);
  localparam int DLT_W = ADDR_W + 1;
  localparam int ACC_W = ADDR_W + 2;

  typedef struct packed {
    logic [PC_W-1:0] pc;
    logic [HW-1:0]   head;
  } idx_word_t;

  // The link valid bit travels with its history entry; it is only read for written entries.
  typedef struct packed {
    logic              lv;
    logic [HW-1:0]     link;
    logic [ADDR_W-1:0] addr;
  } hist_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_WALK_REQ,
    ST_WALK_DATA,
    ST_SEARCH,
    ST_EMIT_REQ,
    ST_EMIT_DATA,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  // Index table control bits and LRU ranks live in flops.
  logic          valid_r [INDEX_ENTRIES];
  logic          valid_nxt [INDEX_ENTRIES];
  logic [IW-1:0] rank_r [INDEX_ENTRIES];
  logic [IW-1:0] rank_nxt [INDEX_ENTRIES];
  logic [HW-1:0] head_r, head_nxt;
  logic          if_valid_r [INFLIGHT_ENTRIES];
  logic          if_valid_nxt [INFLIGHT_ENTRIES];
  logic [ADDR_W-1:0] if_addr_r [INFLIGHT_ENTRIES];
  logic [ADDR_W-1:0] if_addr_nxt [INFLIGHT_ENTRIES];

  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;

  logic [IW-1:0] scan_idx_r, scan_idx_nxt;
  logic          scan_issue_r, scan_issue_nxt;
  logic          eval_vld_r, eval_vld_nxt;
  logic [IW-1:0] eval_idx_r, eval_idx_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] hit_r, hit_nxt;
  logic [HW-1:0] hit_head_r, hit_head_nxt;
  logic          vic_found_r, vic_found_nxt;
  logic [IW-1:0] vic_r, vic_nxt;
  logic [IW-1:0] vic_rank_r, vic_rank_nxt;
  logic [IW-1:0] lru_r, lru_nxt;

  logic [NW-1:0]     n_r, n_nxt;
  logic [HW-1:0]     cur_r, cur_nxt;
  logic [ADDR_W-1:0] acur_r, acur_nxt;
  logic [HW-1:0]     link_r, link_nxt;
  logic              lnk_v_r, lnk_v_nxt;
  logic [HW-1:0]     p_r, p_nxt;
  logic signed [DLT_W-1:0] d0_r, d0_nxt;
  logic signed [DLT_W-1:0] d1_r, d1_nxt;

  logic [NW-1:0] srch_idx_r, srch_idx_nxt;
  logic          s_issue_r, s_issue_nxt;
  logic          sev_vld_r, sev_vld_nxt;
  logic [NW-1:0] sev_idx_r, sev_idx_nxt;
  logic signed [DLT_W-1:0] prev_r, prev_nxt;

  logic [NW-1:0]    m_left_r, m_left_nxt;
  logic [LIM_W-1:0] cnt_r, cnt_nxt;
  logic [LIM_W-1:0] lim_r, lim_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_last_r, out_last_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;

  // Memory ports
  logic       idx_we;
  logic [IW-1:0] idx_waddr;
  idx_word_t  idx_wdata, idx_rdata;
  logic       hist_we;
  hist_word_t hist_wdata, hist_rdata;
  logic       dl_we;
  logic [DW-1:0] dl_raddr;
  logic signed [DLT_W-1:0] dl_wdata, dl_rdata;

  // Scan evaluation
  logic          ev, pcm, hm, kill, va;
  logic [IW-1:0] erank;
  logic          link_ok;
  logic [IW-1:0] tgt, tgt_rank;
  logic [HW-1:0] age_link, age_cur;
  logic signed [ACC_W-1:0] sum;
  logic          sum_bad;
  logic [ADDR_W-1:0] cand;
  logic          dup;
  logic [INFLIGHT_ENTRIES-1:0] free_oh, clr_oh;
  logic [NW-1:0] m_dec;
  logic [LIM_W-1:0] lim_calc;

  function automatic logic [HW-1:0] age_of(input logic [HW-1:0] slot,
                                           input logic [HW-1:0] head);
    logic [HW1-1:0] t;
    t = HW1'(head) + HW1'(HISTORY_ENTRIES - 1) - HW1'(slot);
    if (t >= HW1'(HISTORY_ENTRIES)) begin
      t = t - HW1'(HISTORY_ENTRIES);
    end
    return t[HW-1:0];
  endfunction

  pcdc_ram #(.WIDTH($bits(idx_word_t)), .DEPTH(INDEX_ENTRIES)) u_idx_ram (
    .clk   (clk),
    .we    (idx_we),
    .waddr (idx_waddr),
    .wdata (idx_wdata),
    .raddr (scan_idx_r),
    .rdata (idx_rdata)
  );

  pcdc_ram #(.WIDTH($bits(hist_word_t)), .DEPTH(HISTORY_ENTRIES)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (head_r),
    .wdata (hist_wdata),
    .raddr (link_r),
    .rdata (hist_rdata)
  );

  pcdc_ram #(.WIDTH(DLT_W), .DEPTH(MAX_DELTAS)) u_delta_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (n_r[DW-1:0]),
    .wdata (dl_wdata),
    .raddr (dl_raddr),
    .rdata (dl_rdata)
  );

  assign ev    = valid_r[eval_idx_r];
  assign erank = rank_r[eval_idx_r];
  assign pcm   = (idx_rdata.pc == pc_r);
  assign hm    = (idx_rdata.head == head_r);
  // An entry whose newest history slot is about to be overwritten loses its chain,
  // unless it is the entry of the current pc.
  assign kill  = ev && hm && !pcm;
  assign va    = ev && !kill;

  assign link_ok  = found_r && (hit_head_r != head_r);
  assign tgt      = found_r ? hit_r : (vic_found_r ? vic_r : lru_r);
  assign tgt_rank = rank_r[tgt];

  assign age_link = age_of(link_r, head_r);
  assign age_cur  = age_of(cur_r, head_r);

  assign dl_wdata = DLT_W'({1'b0, acur_r}) - DLT_W'({1'b0, hist_rdata.addr});
  assign sum      = acc_r + ACC_W'(dl_rdata);
  assign sum_bad  = sum[ACC_W-1] || sum[ADDR_W] || (sum[ADDR_W-1:0] >= max_phys_addr);
  assign cand     = sum[ADDR_W-1:0];
  assign m_dec    = m_left_r - NW'(1);
  assign lim_calc = (32'(degree) > 32'(MAX_DEGREE)) ? LIM_W'(MAX_DEGREE) : LIM_W'(degree);

  always_comb begin
    logic seen_free;
    logic seen_clr;
    seen_free = 1'b0;
    seen_clr  = 1'b0;
    dup       = 1'b0;
    free_oh   = '0;
    clr_oh    = '0;
    for (int j = 0; j < INFLIGHT_ENTRIES; j++) begin
      if (if_valid_r[j] && (if_addr_r[j] == cand)) begin
        dup = 1'b1;
      end
      if (!if_valid_r[j] && !seen_free) begin
        free_oh[j] = 1'b1;
        seen_free  = 1'b1;
      end
      if (if_valid_r[j] && (if_addr_r[j] == q_item.addr) && !seen_clr) begin
        clr_oh[j] = 1'b1;
        seen_clr  = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    rank_nxt       = rank_r;
    head_nxt       = head_r;
    if_valid_nxt   = if_valid_r;
    if_addr_nxt    = if_addr_r;
    pc_nxt         = pc_r;
    addr_nxt       = addr_r;
    scan_idx_nxt   = scan_idx_r;
    scan_issue_nxt = scan_issue_r;
    eval_vld_nxt   = 1'b0;
    eval_idx_nxt   = eval_idx_r;
    found_nxt      = found_r;
    hit_nxt        = hit_r;
    hit_head_nxt   = hit_head_r;
    vic_found_nxt  = vic_found_r;
    vic_nxt        = vic_r;
    vic_rank_nxt   = vic_rank_r;
    lru_nxt        = lru_r;
    n_nxt          = n_r;
    cur_nxt        = cur_r;
    acur_nxt       = acur_r;
    link_nxt       = link_r;
    lnk_v_nxt      = lnk_v_r;
    p_nxt          = p_r;
    d0_nxt         = d0_r;
    d1_nxt         = d1_r;
    srch_idx_nxt   = srch_idx_r;
    s_issue_nxt    = s_issue_r;
    sev_vld_nxt    = 1'b0;
    sev_idx_nxt    = sev_idx_r;
    prev_nxt       = prev_r;
    m_left_nxt     = m_left_r;
    cnt_nxt        = cnt_r;
    lim_nxt        = lim_r;
    acc_nxt        = acc_r;
    pend_vld_nxt   = pend_vld_r;
    pend_addr_nxt  = pend_addr_r;
    out_valid_nxt  = 1'b0;
    out_last_nxt   = out_last_r;
    out_addr_nxt   = out_addr_r;
    q_pop          = 1'b0;
    idx_we         = 1'b0;
    idx_waddr      = tgt;
    idx_wdata      = '{pc: pc_r, head: head_r};
    hist_we        = 1'b0;
    hist_wdata     = '{lv: link_ok, link: (link_ok ? hit_head_r : '0), addr: addr_r};
    dl_we          = 1'b0;
    dl_raddr       = srch_idx_r[DW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_item.cmd == CMD_COMPLETE) begin
            for (int j = 0; j < INFLIGHT_ENTRIES; j++) begin
              if (clr_oh[j]) begin
                if_valid_nxt[j] = 1'b0;
              end
            end
          end else begin
            pc_nxt         = q_item.pc;
            addr_nxt       = q_item.addr;
            scan_idx_nxt   = '0;
            scan_issue_nxt = 1'b1;
            found_nxt      = 1'b0;
            vic_found_nxt  = 1'b0;
            state_nxt      = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (scan_issue_r) begin
          eval_vld_nxt = 1'b1;
          eval_idx_nxt = scan_idx_r;
          if (scan_idx_r == IW'(INDEX_ENTRIES - 1)) begin
            scan_issue_nxt = 1'b0;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
        if (eval_vld_r) begin
          if (ev && pcm && !found_r) begin
            found_nxt    = 1'b1;
            hit_nxt      = eval_idx_r;
            hit_head_nxt = idx_rdata.head;
          end
          if (kill) begin
            valid_nxt[eval_idx_r] = 1'b0;
          end
          // Victim: the highest ranked entry left invalid, else the least recent one.
          if (!va && (!vic_found_r || (erank > vic_rank_r))) begin
            vic_found_nxt = 1'b1;
            vic_nxt       = eval_idx_r;
            vic_rank_nxt  = erank;
          end
          if (erank == IW'(INDEX_ENTRIES - 1)) begin
            lru_nxt = eval_idx_r;
          end
          if (eval_idx_r == IW'(INDEX_ENTRIES - 1)) begin
            state_nxt = ST_UPDATE;
          end
        end
      end

      ST_UPDATE: begin
        hist_we        = 1'b1;
        head_nxt       = (head_r == HW'(HISTORY_ENTRIES - 1)) ? '0 : head_r + 1'b1;
        idx_we         = 1'b1;
        valid_nxt[tgt] = 1'b1;
        for (int j = 0; j < INDEX_ENTRIES; j++) begin
          if (rank_r[j] < tgt_rank) begin
            rank_nxt[j] = rank_r[j] + 1'b1;
          end
        end
        rank_nxt[tgt] = '0;
        if (!found_r) begin
          state_nxt = ST_IDLE;
        end else begin
          n_nxt     = '0;
          cur_nxt   = head_r;
          acur_nxt  = addr_r;
          link_nxt  = hit_head_r;
          lnk_v_nxt = link_ok;
          state_nxt = ST_WALK_REQ;
        end
      end

      ST_WALK_REQ: begin
        // A link to a slot that is not older than the current one ends the chain.
        if ((n_r < NW'(MAX_DELTAS)) && lnk_v_r && (age_link > age_cur)) begin
          p_nxt     = link_r;
          state_nxt = ST_WALK_DATA;
        end else if (n_r < NW'(MIN_DELTAS)) begin
          state_nxt = ST_IDLE;
        end else begin
          srch_idx_nxt = NW'(1);
          s_issue_nxt  = 1'b1;
          state_nxt    = ST_SEARCH;
        end
      end

      ST_WALK_DATA: begin
        dl_we = 1'b1;
        if (n_r == NW'(0)) begin
          d0_nxt = dl_wdata;
        end
        if (n_r == NW'(1)) begin
          d1_nxt = dl_wdata;
        end
        n_nxt     = n_r + 1'b1;
        cur_nxt   = p_r;
        acur_nxt  = hist_rdata.addr;
        link_nxt  = hist_rdata.link;
        lnk_v_nxt = hist_rdata.lv;
        state_nxt = ST_WALK_REQ;
      end

      ST_SEARCH: begin
        if (s_issue_r) begin
          sev_vld_nxt = 1'b1;
          sev_idx_nxt = srch_idx_r;
          if (srch_idx_r == n_r - NW'(1)) begin
            s_issue_nxt = 1'b0;
          end else begin
            srch_idx_nxt = srch_idx_r + 1'b1;
          end
        end
        if (sev_vld_r) begin
          prev_nxt = dl_rdata;
          if ((sev_idx_r >= NW'(2)) && (prev_r == d0_r) && (dl_rdata == d1_r)) begin
            m_left_nxt   = sev_idx_r - NW'(1);
            cnt_nxt      = '0;
            lim_nxt      = lim_calc;
            acc_nxt      = ACC_W'({2'b00, addr_r});
            pend_vld_nxt = 1'b0;
            state_nxt    = ST_EMIT_REQ;
          end else if (sev_idx_r == n_r - NW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_EMIT_REQ: begin
        dl_raddr = m_dec[DW-1:0];
        if ((m_left_r != '0) && (cnt_r < lim_r)) begin
          m_left_nxt = m_dec;
          state_nxt  = ST_EMIT_DATA;
        end else begin
          state_nxt = ST_FINISH;
        end
      end

      ST_EMIT_DATA: begin
        if (sum_bad) begin
          state_nxt = ST_FINISH;
        end else begin
          acc_nxt = sum;
          cnt_nxt = cnt_r + 1'b1;
          if (!dup && (free_oh != '0)) begin
            for (int j = 0; j < INFLIGHT_ENTRIES; j++) begin
              if (free_oh[j]) begin
                if_valid_nxt[j] = 1'b1;
                if_addr_nxt[j]  = cand;
              end
            end
            // One candidate is held back so the final beat can carry last.
            if (pend_vld_r) begin
              out_valid_nxt = 1'b1;
              out_addr_nxt  = pend_addr_r;
              out_last_nxt  = 1'b0;
            end
            pend_vld_nxt  = 1'b1;
            pend_addr_nxt = cand;
          end
          state_nxt = ST_EMIT_REQ;
        end
      end

      ST_FINISH: begin
        if (pend_vld_r) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = pend_addr_r;
          out_last_nxt  = 1'b1;
        end
        pend_vld_nxt = 1'b0;
        state_nxt    = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      scan_idx_r   <= '0;
      scan_issue_r <= 1'b0;
      eval_vld_r   <= 1'b0;
      eval_idx_r   <= '0;
      found_r      <= 1'b0;
      vic_found_r  <= 1'b0;
      n_r          <= '0;
      lnk_v_r      <= 1'b0;
      srch_idx_r   <= '0;
      s_issue_r    <= 1'b0;
      sev_vld_r    <= 1'b0;
      sev_idx_r    <= '0;
      m_left_r     <= '0;
      cnt_r        <= '0;
      lim_r        <= '0;
      pend_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
      for (int j = 0; j < INDEX_ENTRIES; j++) begin
        valid_r[j] <= 1'b0;
        rank_r[j]  <= IW'(j);
      end
      for (int j = 0; j < INFLIGHT_ENTRIES; j++) begin
        if_valid_r[j] <= 1'b0;
      end
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      scan_idx_r   <= scan_idx_nxt;
      scan_issue_r <= scan_issue_nxt;
      eval_vld_r   <= eval_vld_nxt;
      eval_idx_r   <= eval_idx_nxt;
      found_r      <= found_nxt;
      vic_found_r  <= vic_found_nxt;
      n_r          <= n_nxt;
      lnk_v_r      <= lnk_v_nxt;
      srch_idx_r   <= srch_idx_nxt;
      s_issue_r    <= s_issue_nxt;
      sev_vld_r    <= sev_vld_nxt;
      sev_idx_r    <= sev_idx_nxt;
      m_left_r     <= m_left_nxt;
      cnt_r        <= cnt_nxt;
      lim_r        <= lim_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_valid_r  <= out_valid_nxt;
      out_last_r   <= out_last_nxt;
      valid_r      <= valid_nxt;
      rank_r       <= rank_nxt;
      if_valid_r   <= if_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pc_r        <= pc_nxt;
    addr_r      <= addr_nxt;
    hit_r       <= hit_nxt;
    hit_head_r  <= hit_head_nxt;
    vic_r       <= vic_nxt;
    vic_rank_r  <= vic_rank_nxt;
    lru_r       <= lru_nxt;
    cur_r       <= cur_nxt;
    acur_r      <= acur_nxt;
    link_r      <= link_nxt;
    p_r         <= p_nxt;
    d0_r        <= d0_nxt;
    d1_r        <= d1_nxt;
    prev_r      <= prev_nxt;
    acc_r       <= acc_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_addr_r  <= out_addr_nxt;
    if_addr_r   <= if_addr_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_addr  = out_addr_r;
  assign out_last  = out_last_r;

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (state_r == ST_IDLE))
    else $error("final beat while the item is still in progress");

  a_mid_beat_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == ST_EMIT_REQ))
    else $error("non-final beat outside candidate generation");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> ((state_r == ST_IDLE) && !q_empty))
    else $error("queue popped while busy or empty");

  a_search_enough_deltas: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (n_r >= NW'(MIN_DELTAS)))
    else $error("delta search started with too short a chain");

endmodule
`default_nettype wire
